// ===== src/ktx1_pkg.sv =====
package ktx1_pkg;

	// phase codes
	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_KV     = 3'd1;
	localparam logic [2:0] PH_SIZE   = 3'd2;
	localparam logic [2:0] PH_DATA   = 3'd3;
	localparam logic [2:0] PH_PAD    = 3'd4;
	localparam logic [2:0] PH_DONE   = 3'd5;

	// status codes
	localparam logic [3:0] ST_OK       = 4'd0;
	localparam logic [3:0] ST_SMALL    = 4'd1;
	localparam logic [3:0] ST_SIG      = 4'd2;
	localparam logic [3:0] ST_ENDIAN   = 4'd3;
	localparam logic [3:0] ST_TYPE     = 4'd4;
	localparam logic [3:0] ST_TYPESIZE = 4'd5;
	localparam logic [3:0] ST_GLFMT    = 4'd6;
	localparam logic [3:0] ST_FACES    = 4'd7;
	localparam logic [3:0] ST_DEPTH    = 4'd8;
	localparam logic [3:0] ST_ARRAY    = 4'd9;
	localparam logic [3:0] ST_FORMAT   = 4'd10;
	localparam logic [3:0] ST_MIPS     = 4'd11;
	localparam logic [3:0] ST_TRUNC    = 4'd12;

	// result kinds
	localparam logic KIND_MIP   = 1'b0;
	localparam logic KIND_FINAL = 1'b1;

	// file identifier as three little-endian words
	localparam logic [31:0] SIG_W0 = 32'h5854_4BAB;
	localparam logic [31:0] SIG_W1 = 32'hBB31_3120;
	localparam logic [31:0] SIG_W2 = 32'h0A1A_0A0D;

	localparam logic [31:0] ENDIAN_NATIVE = 32'h0403_0201;
	localparam logic [31:0] ENDIAN_SWAP   = 32'h0102_0304;

	localparam logic [31:0] FMT_ASTC6_UNORM = 32'h0000_93B4;
	localparam logic [31:0] FMT_ASTC6_SRGB  = 32'h0000_93D4;

	localparam int MIP_LIMIT_DEF = 16;

	localparam int TDATA_W = 184;

	typedef struct packed {
		logic        kind;
		logic [3:0]  status;
		logic [4:0]  mip_index;
		logic [31:0] mip_size;
		logic [31:0] data_offset;
		logic [31:0] mip_width;
		logic [31:0] mip_height;
		logic [35:0] total_size;
		logic        format_code;
		logic [5:0]  mip_count;
		logic        last;
	} result_t;

	function automatic logic [31:0] bswap32(logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	function automatic result_t mk_final(logic [3:0] st, logic [35:0] tot, logic fmt,
			logic [5:0] cnt);
		result_t r;
		r = '0;
		r.kind = KIND_FINAL;
		r.status = st;
		if (st == ST_OK || st == ST_TRUNC) begin
			r.total_size = tot;
			r.format_code = fmt;
			r.mip_count = cnt;
		end
		return r;
	endfunction

	function automatic result_t mk_mip(logic [4:0] idx, logic [31:0] sz, logic [31:0] off,
			logic [31:0] w, logic [31:0] h, logic fmt);
		result_t r;
		r = '0;
		r.kind = KIND_MIP;
		r.status = ST_OK;
		r.mip_index = idx;
		r.mip_size = sz;
		r.data_offset = off;
		r.mip_width = w;
		r.mip_height = h;
		r.format_code = fmt;
		return r;
	endfunction

endpackage

// ===== src/ktx1_texture_header_parser.sv =====
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: file_byte; tlast: last_byte
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: result fields; tuser: result_kind;
//                                               tlast: last_of_run
//
// One byte request per cycle. A byte sits in the input register, is
// parsed there and its zero, one or two results land in a four-entry result queue.
// The queue sets the rate: the input register moves on while two slots are free,
// so a byte that makes two results (mip record plus final status) plus a stalled
// output can hold input off. Results leave one per cycle from the queue head while m_axis_tready is high.
// Reset clears phase, counters, queue and input register; the header words are
// written before they are read and carry no reset.
module ktx1_texture_header_parser #(
	parameter int MIP_LIMIT = ktx1_pkg::MIP_LIMIT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,  // [7:0] file_byte
	input  logic                         s_axis_tlast,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [3:0] status, [8:4] mip_index, [40:9] mip_size, [72:41] data_offset,
	// [104:73] mip_width, [136:105] mip_height, [172:137] total_size,
	// [173] format_code, [179:174] mip_count, [183:180] zero
	output logic [ktx1_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic [0:0]                   m_axis_tuser,  // [0] result_kind
	output logic                         m_axis_tlast
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv;

	// parser state
	logic [2:0]  phase_q;
	logic [31:0] store_q [16];
	logic [31:0] pos_q;
	logic [31:0] skip_q;
	logic [23:0] wa_q;
	logic [5:0]  ml_q;      // mips still to read
	logic [5:0]  nm_q;      // mip count from header
	logic [4:0]  mc_q;
	logic [31:0] cw_q;
	logic [31:0] ch_q;
	logic [35:0] sum_q;
	logic        swp_q;
	logic        fmt_q;

	logic [2:0]  phase_nx;
	logic [31:0] pos_nx;
	logic [31:0] skip_nx;
	logic [23:0] wa_nx;
	logic [5:0]  ml_nx;
	logic [5:0]  nm_nx;
	logic [4:0]  mc_nx;
	logic [31:0] cw_nx;
	logic [31:0] ch_nx;
	logic [35:0] sum_nx;
	logic        swp_nx;
	logic        fmt_nx;

	// result queue
	ktx1_pkg::result_t fifo_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] cnt_q;
	logic       pop;

	ktx1_pkg::result_t r0;
	ktx1_pkg::result_t r1;
	logic              have0;
	logic              have1;

	// header view
	logic [31:0] hw [16];
	logic        swp_hdr;
	logic        fmt_hdr;
	logic [3:0]  hdr_st;

	// step scratch
	logic        do_after;
	logic        do_enter;
	logic [1:0]  pad;
	logic [1:0]  k;
	logic [31:0] raw_sz;
	logic [31:0] sz;
	ktx1_pkg::result_t fin;

	assign adv = valid_s1 && (cnt_q <= 3'd2);
	assign s_axis_tready = !valid_s1 || adv;
	assign pop = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// header words; byte 63 is merged live into the last word
	assign swp_hdr = (store_q[3] == ktx1_pkg::ENDIAN_SWAP);

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			if (i == 15) begin
				hw[i] = swp_hdr ? ktx1_pkg::bswap32({byte_s1, store_q[15][23:0]})
					: {byte_s1, store_q[15][23:0]};
			end else begin
				hw[i] = swp_hdr ? ktx1_pkg::bswap32(store_q[i]) : store_q[i];
			end
		end
	end

	assign fmt_hdr = (hw[7] == ktx1_pkg::FMT_ASTC6_SRGB);

	always_comb begin
		if (store_q[0] != ktx1_pkg::SIG_W0 || store_q[1] != ktx1_pkg::SIG_W1 ||
				store_q[2] != ktx1_pkg::SIG_W2) begin
			hdr_st = ktx1_pkg::ST_SIG;
		end else if (store_q[3] != ktx1_pkg::ENDIAN_NATIVE &&
				store_q[3] != ktx1_pkg::ENDIAN_SWAP) begin
			hdr_st = ktx1_pkg::ST_ENDIAN;
		end else if (hw[4] != 32'd0) begin
			hdr_st = ktx1_pkg::ST_TYPE;
		end else if (hw[5] != 32'd1) begin
			hdr_st = ktx1_pkg::ST_TYPESIZE;
		end else if (hw[6] != 32'd0) begin
			hdr_st = ktx1_pkg::ST_GLFMT;
		end else if (hw[13] != 32'd1) begin
			hdr_st = ktx1_pkg::ST_FACES;
		end else if (hw[11] != 32'd0) begin
			hdr_st = ktx1_pkg::ST_DEPTH;
		end else if (hw[12] != 32'd0) begin
			hdr_st = ktx1_pkg::ST_ARRAY;
		end else if (hw[7] != ktx1_pkg::FMT_ASTC6_UNORM &&
				hw[7] != ktx1_pkg::FMT_ASTC6_SRGB) begin
			hdr_st = ktx1_pkg::ST_FORMAT;
		end else if (hw[14] > 32'(MIP_LIMIT)) begin
			hdr_st = ktx1_pkg::ST_MIPS;
		end else begin
			hdr_st = ktx1_pkg::ST_OK;
		end
	end

	// one parse step for the byte in the input register
	always_comb begin
		phase_nx = phase_q;
		pos_nx = pos_q + 32'd1;
		skip_nx = skip_q;
		wa_nx = wa_q;
		ml_nx = ml_q;
		nm_nx = nm_q;
		mc_nx = mc_q;
		cw_nx = cw_q;
		ch_nx = ch_q;
		sum_nx = sum_q;
		swp_nx = swp_q;
		fmt_nx = fmt_q;
		r0 = '0;
		r1 = '0;
		have0 = 1'b0;
		have1 = 1'b0;
		do_after = 1'b0;
		do_enter = 1'b0;
		pad = 2'd0;
		k = 2'(2'd0 - skip_q[1:0]);
		raw_sz = {byte_s1, wa_q};
		sz = swp_q ? ktx1_pkg::bswap32(raw_sz) : raw_sz;
		fin = '0;

		case (phase_q)
			ktx1_pkg::PH_HEADER: begin
				if (pos_q[5:0] == 6'd63) begin
					swp_nx = swp_hdr;
					fmt_nx = fmt_hdr;
					if (hdr_st != ktx1_pkg::ST_OK) begin
						r0 = ktx1_pkg::mk_final(hdr_st, 36'd0, 1'b0, 6'd0);
						have0 = 1'b1;
						phase_nx = ktx1_pkg::PH_DONE;
					end else begin
						ml_nx = hw[14][5:0];
						nm_nx = hw[14][5:0];
						cw_nx = hw[9];
						ch_nx = hw[10];
						skip_nx = hw[15];
						phase_nx = ktx1_pkg::PH_KV;
						do_enter = (hw[15] == 32'd0);
					end
				end
			end
			ktx1_pkg::PH_KV, ktx1_pkg::PH_PAD: begin
				skip_nx = skip_q - 32'd1;
				do_enter = (skip_q == 32'd1);
			end
			ktx1_pkg::PH_DATA: begin
				skip_nx = skip_q - 32'd1;
				do_after = (skip_q == 32'd1);
			end
			ktx1_pkg::PH_SIZE: begin
				if (skip_q != 32'd1) begin
					case (k)
						2'd0: wa_nx = wa_q | {16'd0, byte_s1};
						2'd1: wa_nx = wa_q | {8'd0, byte_s1, 8'd0};
						2'd2: wa_nx = wa_q | {byte_s1, 16'd0};
						default: wa_nx = wa_q;
					endcase
					skip_nx = skip_q - 32'd1;
				end else begin
					r0 = ktx1_pkg::mk_mip(mc_q, sz, pos_nx, cw_q, ch_q, fmt_q);
					have0 = 1'b1;
					sum_nx = sum_q + {4'd0, sz};
					cw_nx = (cw_q[31:1] == 31'd0) ? 32'd1 : {1'b0, cw_q[31:1]};
					ch_nx = (ch_q[31:1] == 31'd0) ? 32'd1 : {1'b0, ch_q[31:1]};
					mc_nx = mc_q + 5'd1;
					ml_nx = ml_q - 6'd1;
					wa_nx = 24'd0;
					phase_nx = ktx1_pkg::PH_DATA;
					skip_nx = sz;
					do_after = (sz == 32'd0);
				end
			end
			default: begin
			end
		endcase

		// end of a mip's data: pad to a word boundary if more mips follow
		if (do_after) begin
			pad = 2'(2'd0 - pos_nx[1:0]);
			if (ml_nx != 6'd0 && pad != 2'd0) begin
				phase_nx = ktx1_pkg::PH_PAD;
				skip_nx = {30'd0, pad};
			end else begin
				do_enter = 1'b1;
			end
		end

		if (do_enter) begin
			if (ml_nx == 6'd0) begin
				fin = ktx1_pkg::mk_final(ktx1_pkg::ST_OK, sum_nx, fmt_nx, 6'(nm_nx - ml_nx));
				if (have0) begin
					r1 = fin;
					have1 = 1'b1;
				end else begin
					r0 = fin;
					have0 = 1'b1;
				end
				phase_nx = ktx1_pkg::PH_DONE;
			end else begin
				phase_nx = ktx1_pkg::PH_SIZE;
				skip_nx = 32'd4;
				wa_nx = 24'd0;
			end
		end

		// end of file: close out and start over
		if (last_s1) begin
			if (phase_nx != ktx1_pkg::PH_DONE) begin
				fin = ktx1_pkg::mk_final((phase_nx == ktx1_pkg::PH_HEADER) ?
					ktx1_pkg::ST_SMALL : ktx1_pkg::ST_TRUNC,
					sum_nx, fmt_nx, 6'(nm_nx - ml_nx));
				if (have0) begin
					r1 = fin;
					have1 = 1'b1;
				end else begin
					r0 = fin;
					have0 = 1'b1;
				end
			end
			phase_nx = ktx1_pkg::PH_HEADER;
			pos_nx = 32'd0;
			skip_nx = 32'd0;
			wa_nx = 24'd0;
			ml_nx = 6'd0;
			nm_nx = 6'd0;
			mc_nx = 5'd0;
			cw_nx = 32'd0;
			ch_nx = 32'd0;
			sum_nx = 36'd0;
			swp_nx = 1'b0;
			fmt_nx = 1'b0;
		end

		if (have1) begin
			r1.last = 1'b1;
		end else if (have0) begin
			r0.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ktx1_pkg::PH_HEADER;
			pos_q <= 32'd0;
			skip_q <= 32'd0;
			wa_q <= 24'd0;
			ml_q <= 6'd0;
			nm_q <= 6'd0;
			mc_q <= 5'd0;
			cw_q <= 32'd0;
			ch_q <= 32'd0;
			sum_q <= 36'd0;
			swp_q <= 1'b0;
			fmt_q <= 1'b0;
		end else if (adv) begin
			phase_q <= phase_nx;
			pos_q <= pos_nx;
			skip_q <= skip_nx;
			wa_q <= wa_nx;
			ml_q <= ml_nx;
			nm_q <= nm_nx;
			mc_q <= mc_nx;
			cw_q <= cw_nx;
			ch_q <= ch_nx;
			sum_q <= sum_nx;
			swp_q <= swp_nx;
			fmt_q <= fmt_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && phase_q == ktx1_pkg::PH_HEADER) begin
			store_q[pos_q[5:2]][{pos_q[1:0], 3'b000} +: 8] <= byte_s1;
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (adv && have0) begin
			fifo_q[wr_ptr_q] <= r0;
		end
		if (adv && have1) begin
			fifo_q[wr_ptr_q + 2'd1] <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (adv) begin
				wr_ptr_q <= wr_ptr_q + {1'b0, have0} + {1'b0, have1};
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + (adv ? ({2'd0, have0} + {2'd0, have1}) : 3'd0)
				- {2'd0, pop};
		end
	end

	assign m_axis_tvalid = (cnt_q != 3'd0);
	assign m_axis_tuser = fifo_q[rd_ptr_q].kind;
	assign m_axis_tlast = fifo_q[rd_ptr_q].last;
	assign m_axis_tdata = {4'd0,
		fifo_q[rd_ptr_q].mip_count,
		fifo_q[rd_ptr_q].format_code,
		fifo_q[rd_ptr_q].total_size,
		fifo_q[rd_ptr_q].mip_height,
		fifo_q[rd_ptr_q].mip_width,
		fifo_q[rd_ptr_q].data_offset,
		fifo_q[rd_ptr_q].mip_size,
		fifo_q[rd_ptr_q].mip_index,
		fifo_q[rd_ptr_q].status};

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("result queue overflow");

	a_file_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> phase_q == ktx1_pkg::PH_HEADER && pos_q == 32'd0)
		else $error("parser did not restart after last byte");

	a_skip_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == ktx1_pkg::PH_KV || phase_q == ktx1_pkg::PH_DATA ||
		phase_q == ktx1_pkg::PH_PAD) |-> skip_q != 32'd0)
		else $error("skip phase with nothing to skip");

	a_mips_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ml_q <= nm_q)
		else $error("more mips left than in header");

	a_header_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == ktx1_pkg::PH_HEADER |-> pos_q < 32'd64)
		else $error("header phase past byte 63");

endmodule

// ===== verif/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Longest test stays far below SETTLE_LIMIT; trips only on a hung handshake.
	localparam int TAIL_CYCLES = 20;
	localparam int SETTLE_LIMIT = 5000;
	localparam int RANDOM_BYTES = 200;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata = 8'h00;   // [7:0] file_byte
	logic                s_axis_tlast = 1'b0;    // last_byte
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	// [3:0] status, [8:4] mip_index, [40:9] mip_size, [72:41] data_offset,
	// [104:73] mip_width, [136:105] mip_height, [172:137] total_size,
	// [173] format_code, [179:174] mip_count, [183:180] zero
	logic [ktx1_pkg::TDATA_W-1:0] m_axis_tdata;
	logic [0:0]          m_axis_tuser;           // [0] result_kind
	logic                m_axis_tlast;           // last_of_run

	ktx1_texture_header_parser #(
		.MIP_LIMIT(ktx1_pkg::MIP_LIMIT_DEF)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Parser shadow state, advanced once per accepted byte request
	// ------------------------------------------------------------------
	logic [2:0]  prs_phase;
	logic [31:0] hdr_words [16];
	logic [31:0] byte_pos;
	logic [31:0] skip_left;
	logic [23:0] word_acc;
	logic [5:0]  mips_togo;
	logic [4:0]  level_ctr;
	logic [31:0] lvl_width;
	logic [31:0] lvl_height;
	logic [35:0] size_total;
	logic        swapped;
	logic        fmt_srgb;

	ktx1_pkg::result_t parse_results [$];   // results owed by the DUT, oldest first
	ktx1_pkg::result_t head_result;

	// run bookkeeping
	int errors = 0;
	int results_seen = 0;
	int bytes_sent = 0;
	int files_sent = 0;
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	int hold_req = 0;                 // long receiver hold, picked up by the sink
	int rx_wait = 0;

	// file under construction
	logic [7:0]  file_q [$];
	logic [31:0] hdr_val [16];
	logic [31:0] mip_len [16];
	logic        file_big;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic logic [31:0] swap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	// header word as seen through the selected byte order
	function automatic logic [31:0] hdr_field(input int i);
		return swapped ? swap32(hdr_words[i]) : hdr_words[i];
	endfunction

	task automatic prs_reset();
		prs_phase = ktx1_pkg::PH_HEADER;
		for (int i = 0; i < 16; i++) hdr_words[i] = '0;
		byte_pos = '0;
		skip_left = '0;
		word_acc = '0;
		mips_togo = '0;
		level_ctr = '0;
		lvl_width = '0;
		lvl_height = '0;
		size_total = '0;
		swapped = 1'b0;
		fmt_srgb = 1'b0;
	endtask

	task automatic emit_final(input logic [3:0] st);
		ktx1_pkg::result_t r;
		logic [31:0] done_cnt;
		r = '0;
		r.kind = ktx1_pkg::KIND_FINAL;
		r.status = st;
		// totals only ride along on a clean end or a truncated one
		if (st == ktx1_pkg::ST_OK || st == ktx1_pkg::ST_TRUNC) begin
			done_cnt = hdr_field(14) - {26'd0, mips_togo};
			r.total_size = size_total;
			r.format_code = fmt_srgb;
			r.mip_count = done_cnt[5:0];
		end
		parse_results.push_back(r);
		prs_phase = ktx1_pkg::PH_DONE;
	endtask

	task automatic next_level_or_done();
		if (mips_togo == 0) begin
			emit_final(ktx1_pkg::ST_OK);
		end else begin
			prs_phase = ktx1_pkg::PH_SIZE;
			skip_left = 32'd4;
			word_acc = '0;
		end
	endtask

	// pad to a 4-byte boundary only while more levels follow
	task automatic end_of_image();
		logic [31:0] neg;
		neg = 32'd0 - byte_pos;
		if (mips_togo != 0 && neg[1:0] != 2'd0) begin
			prs_phase = ktx1_pkg::PH_PAD;
			skip_left = {30'd0, neg[1:0]};
		end else begin
			next_level_or_done();
		end
	endtask

	task automatic check_hdr(output logic [3:0] st);
		st = ktx1_pkg::ST_OK;
		if (hdr_words[0] != ktx1_pkg::SIG_W0 || hdr_words[1] != ktx1_pkg::SIG_W1 ||
				hdr_words[2] != ktx1_pkg::SIG_W2)
			st = ktx1_pkg::ST_SIG;
		if (st == ktx1_pkg::ST_OK) begin
			if (hdr_words[3] == ktx1_pkg::ENDIAN_NATIVE) swapped = 1'b0;
			else if (hdr_words[3] == ktx1_pkg::ENDIAN_SWAP) swapped = 1'b1;
			else st = ktx1_pkg::ST_ENDIAN;
		end
		if (st == ktx1_pkg::ST_OK) begin
			if (hdr_field(4) != 32'd0) st = ktx1_pkg::ST_TYPE;
			else if (hdr_field(5) != 32'd1) st = ktx1_pkg::ST_TYPESIZE;
			else if (hdr_field(6) != 32'd0) st = ktx1_pkg::ST_GLFMT;
			else if (hdr_field(13) != 32'd1) st = ktx1_pkg::ST_FACES;
			else if (hdr_field(11) != 32'd0) st = ktx1_pkg::ST_DEPTH;
			else if (hdr_field(12) != 32'd0) st = ktx1_pkg::ST_ARRAY;
			else if (hdr_field(7) == ktx1_pkg::FMT_ASTC6_UNORM) fmt_srgb = 1'b0;
			else if (hdr_field(7) == ktx1_pkg::FMT_ASTC6_SRGB) fmt_srgb = 1'b1;
			else st = ktx1_pkg::ST_FORMAT;
			if (st == ktx1_pkg::ST_OK && hdr_field(14) > ktx1_pkg::MIP_LIMIT_DEF)
				st = ktx1_pkg::ST_MIPS;
		end
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic eof);
		logic [31:0] pos, w, raw, sz;
		logic [3:0]  st;
		int          n_prior, k;
		ktx1_pkg::result_t r;
		n_prior = parse_results.size();
		pos = byte_pos;
		byte_pos = pos + 32'd1;
		case (prs_phase)
			ktx1_pkg::PH_HEADER: begin
				k = int'(pos[1:0]);
				w = hdr_words[pos[5:2]];
				w[8*k +: 8] = b;
				hdr_words[pos[5:2]] = w;
				if (pos >= 32'd63) begin
					check_hdr(st);
					if (st != ktx1_pkg::ST_OK) begin
						emit_final(st);
					end else begin
						w = hdr_field(14);
						mips_togo = w[5:0];
						lvl_width = hdr_field(9);
						lvl_height = hdr_field(10);
						skip_left = hdr_field(15);
						prs_phase = ktx1_pkg::PH_KV;
						if (skip_left == 0) next_level_or_done();
					end
				end
			end
			ktx1_pkg::PH_KV, ktx1_pkg::PH_PAD: begin
				skip_left = skip_left - 32'd1;
				if (skip_left == 0) next_level_or_done();
			end
			ktx1_pkg::PH_SIZE: begin
				w = (32'd4 - skip_left) & 32'd3;
				k = int'(w);
				if (skip_left > 32'd1) begin
					word_acc = word_acc | ({16'd0, b} << (8 * k));
					skip_left = skip_left - 32'd1;
				end else begin
					raw = {b, word_acc};
					sz = swapped ? swap32(raw) : raw;
					r = '0;
					r.kind = ktx1_pkg::KIND_MIP;
					r.status = ktx1_pkg::ST_OK;
					r.mip_index = level_ctr;
					r.mip_size = sz;
					r.data_offset = byte_pos;
					r.mip_width = lvl_width;
					r.mip_height = lvl_height;
					r.format_code = fmt_srgb;
					parse_results.push_back(r);
					size_total = size_total + {4'd0, sz};
					lvl_width = lvl_width / 2;
					if (lvl_width == 0) lvl_width = 32'd1;
					lvl_height = lvl_height / 2;
					if (lvl_height == 0) lvl_height = 32'd1;
					level_ctr = level_ctr + 5'd1;
					mips_togo = mips_togo - 6'd1;
					word_acc = '0;
					prs_phase = ktx1_pkg::PH_DATA;
					skip_left = sz;
					if (sz == 0) end_of_image();
				end
			end
			ktx1_pkg::PH_DATA: begin
				skip_left = skip_left - 32'd1;
				if (skip_left == 0) end_of_image();
			end
			default: ;
		endcase
		// end of file: report whatever is still open, then start over
		if (eof) begin
			if (prs_phase != ktx1_pkg::PH_DONE)
				emit_final((prs_phase == ktx1_pkg::PH_HEADER) ? ktx1_pkg::ST_SMALL
					: ktx1_pkg::ST_TRUNC);
			prs_reset();
		end
		if (parse_results.size() > n_prior) begin
			r = parse_results.pop_back();
			r.last = 1'b1;
			parse_results.push_back(r);
		end
	endtask

	// ------------------------------------------------------------------
	// Source side: one byte request, then a random gap
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic eof);
		int g;
		s_axis_tdata <= b;
		s_axis_tlast <= eof;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_byte(b, eof);
		bytes_sent++;
		g = tx_idle_en ? gap_len() : 0;
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// cut < 0 or past the end sends the whole file, else last_byte lands on index cut
	task automatic send_file(input int cut);
		int n;
		n = (cut < 0 || cut >= file_q.size()) ? file_q.size() : cut + 1;
		for (int i = 0; i < n; i++) send_byte(file_q[i], i == n - 1);
		files_sent++;
	endtask

	// wait until the DUT owes nothing, then let the pipe run dry
	task automatic settle();
		int spin;
		s_axis_tvalid <= 1'b0;
		spin = 0;
		while (parse_results.size() != 0 && spin < SETTLE_LIMIT) begin
			@(posedge clk);
			spin++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// File builder
	// ------------------------------------------------------------------
	task automatic put_word(input logic [31:0] w, input logic big);
		if (big) begin
			file_q.push_back(w[31:24]);
			file_q.push_back(w[23:16]);
			file_q.push_back(w[15:8]);
			file_q.push_back(w[7:0]);
		end else begin
			file_q.push_back(w[7:0]);
			file_q.push_back(w[15:8]);
			file_q.push_back(w[23:16]);
			file_q.push_back(w[31:24]);
		end
	endtask

	task automatic add_junk(input int n);
		repeat (n) file_q.push_back(8'($urandom));
	endtask

	task automatic build_header(input logic big, input logic srgb, input int nmips,
			input logic [31:0] w, input logic [31:0] h, input int kv);
		file_big = big;
		hdr_val[4] = 32'd0;
		hdr_val[5] = 32'd1;
		hdr_val[6] = 32'd0;
		hdr_val[7] = srgb ? ktx1_pkg::FMT_ASTC6_SRGB : ktx1_pkg::FMT_ASTC6_UNORM;
		hdr_val[8] = $urandom;          // base internal format is never checked
		hdr_val[9] = w;
		hdr_val[10] = h;
		hdr_val[11] = 32'd0;
		hdr_val[12] = 32'd0;
		hdr_val[13] = 32'd1;
		hdr_val[14] = nmips;
		hdr_val[15] = kv;
	endtask

	task automatic emit_header();
		file_q.delete();
		put_word(ktx1_pkg::SIG_W0, 1'b0);
		put_word(ktx1_pkg::SIG_W1, 1'b0);
		put_word(ktx1_pkg::SIG_W2, 1'b0);
		// written big-endian this reads back as the swapped marker
		put_word(ktx1_pkg::ENDIAN_NATIVE, file_big);
		for (int i = 4; i < 16; i++) put_word(hdr_val[i], file_big);
	endtask

	// key-value bytes, then size word, data and padding per level
	task automatic emit_body(input int data_cap);
		int kv, nm, n;
		kv = (hdr_val[15] > 64) ? 64 : hdr_val[15];
		nm = (hdr_val[14] > 16) ? 16 : hdr_val[14];
		add_junk(kv);
		for (int i = 0; i < nm; i++) begin
			put_word(mip_len[i], file_big);
			n = (mip_len[i] > data_cap) ? data_cap : mip_len[i];
			add_junk(n);
			if (i < nm - 1) while (file_q.size() % 4 != 0) add_junk(1);
		end
	endtask

	// ------------------------------------------------------------------
	// Sink side: random stalls, plus a long hold on request
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_req > 0) begin
			rx_wait = hold_req;
			hold_req = 0;
		end
		if (rx_wait > 0) begin
			m_axis_tready <= 1'b0;
			rx_wait--;
		end else begin
			m_axis_tready <= 1'b1;
			if (rx_idle_en) rx_wait = gap_len();
		end
	end

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] have);
		if (want !== have) begin
			errors++;
			if (errors < 60)
				$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, have);
		end
	endtask

	// every accepted result is matched against the oldest owed one
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (parse_results.size() == 0) begin
				errors++;
				if (errors < 60)
					$display("%0t ns: unexpected result, expected none, got tdata %h", $time,
						m_axis_tdata);
			end else begin
				head_result = parse_results.pop_front();
				check_field("result_kind", 64'(head_result.kind), 64'(m_axis_tuser[0]));
				check_field("status", 64'(head_result.status), 64'(m_axis_tdata[3:0]));
				check_field("mip_index", 64'(head_result.mip_index), 64'(m_axis_tdata[8:4]));
				check_field("mip_size", 64'(head_result.mip_size), 64'(m_axis_tdata[40:9]));
				check_field("data_offset", 64'(head_result.data_offset),
					64'(m_axis_tdata[72:41]));
				check_field("mip_width", 64'(head_result.mip_width),
					64'(m_axis_tdata[104:73]));
				check_field("mip_height", 64'(head_result.mip_height),
					64'(m_axis_tdata[136:105]));
				check_field("total_size", 64'(head_result.total_size),
					64'(m_axis_tdata[172:137]));
				check_field("format_code", 64'(head_result.format_code),
					64'(m_axis_tdata[173]));
				check_field("mip_count", 64'(head_result.mip_count),
					64'(m_axis_tdata[179:174]));
				check_field("tdata pad", 64'd0, 64'(m_axis_tdata[183:180]));
				check_field("last_of_run", 64'(head_result.last), 64'(m_axis_tlast));
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// files that stop inside or right at the end of the header
	task automatic test_short_files();
		build_header(1'b0, 1'b0, 1, 32'd16, 32'd16, 0);
		emit_header();
		send_file(0);
		send_file(62);
		// full header, then end before any key-value byte
		build_header(1'b0, 1'b0, 1, 32'd8, 32'd8, 4);
		emit_header();
		send_file(63);
	endtask

	// one file per header check, alternating byte order
	task automatic test_header_checks();
		int fld;
		logic [31:0] bad;
		build_header(1'b1, 1'b0, 1, 32'd4, 32'd4, 0);
		emit_header();
		file_q[6] = file_q[6] ^ 8'h40;                      // signature byte 6
		add_junk(3);
		send_file(-1);
		build_header(1'b0, 1'b0, 1, 32'd4, 32'd4, 0);
		emit_header();
		file_q[13] = 8'h05;                                 // bad endianness word
		add_junk(2);
		send_file(-1);
		for (int i = 0; i < 8; i++) begin
			case (i)
				0: begin fld = 4;  bad = 32'h0000_1401; end   // glType
				1: begin fld = 5;  bad = 32'd4;         end   // glTypeSize
				2: begin fld = 6;  bad = 32'h0000_1908; end   // glFormat
				3: begin fld = 13; bad = 32'd6;         end   // faces
				4: begin fld = 11; bad = 32'd1;         end   // pixel depth
				5: begin fld = 12; bad = 32'd2;         end   // array elements
				6: begin fld = 7;  bad = 32'h0000_8C40; end   // not ASTC 6x6
				default: begin fld = 14; bad = ktx1_pkg::MIP_LIMIT_DEF + 1; end
			endcase
			build_header(i[0], i[1], 1, 32'd4, 32'd4, 0);
			hdr_val[fld] = bad;
			emit_header();
			add_junk(i % 3);
			send_file(-1);
		end
	endtask

	// clean files in both byte orders and formats, no idling at all
	task automatic test_byte_orders();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		for (int big = 0; big < 2; big++) begin
			build_header(big[0], big[0], 3, 32'd64, 32'd32, 8);
			mip_len[0] = 32'd5;
			mip_len[1] = 32'd3;
			mip_len[2] = 32'd7;
			emit_header();
			emit_body(64);
			send_file(-1);
		end
		settle();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	// no levels: done at header end (trailing bytes ignored) or at key-value end
	task automatic test_zero_mips();
		build_header(1'b0, 1'b1, 0, 32'd100, 32'd50, 0);
		emit_header();
		add_junk(3);
		send_file(-1);
		build_header(1'b1, 1'b0, 0, 32'd7, 32'd9, 6);
		emit_header();
		emit_body(64);
		send_file(-1);
	endtask

	// zero-size levels; the last one closes the file on its size word,
	// which also carries last_byte: mip record and status from one byte
	task automatic test_empty_mips();
		build_header(1'b1, 1'b1, 4, 32'd3, 32'd5, 4);
		mip_len[0] = 32'd0;
		mip_len[1] = 32'd2;
		mip_len[2] = 32'd0;
		mip_len[3] = 32'd0;
		emit_header();
		emit_body(64);
		send_file(-1);
	endtask

	// key-value length not a multiple of 4: first size word is unaligned
	task automatic test_unaligned_kv();
		build_header(1'b0, 1'b0, 2, 32'd33, 32'd17, 5);
		mip_len[0] = 32'd3;
		mip_len[1] = 32'd1;
		emit_header();
		emit_body(64);
		send_file(-1);
	endtask

	// full level chain with extreme dimensions, including a zero width
	task automatic test_mip_limit();
		build_header(1'b0, 1'b1, ktx1_pkg::MIP_LIMIT_DEF, 32'd0, 32'hFFFF_FFFF, 0);
		for (int i = 0; i < 16; i++) mip_len[i] = 32'd0;
		emit_header();
		emit_body(64);
		send_file(-1);
	endtask

	// same file cut in key-value, on a size word's last byte and in padding;
	// layout: kv 64..69, size 70..73, data 74..79, size 80..83, data 84..88,
	// pad 89..91, size 92..95, data 96..97
	task automatic test_truncation();
		int cuts [3];
		cuts[0] = 66;
		cuts[1] = 73;
		cuts[2] = 90;
		build_header(1'b0, 1'b0, 3, 32'd40, 32'd40, 6);
		mip_len[0] = 32'd6;
		mip_len[1] = 32'd5;
		mip_len[2] = 32'd2;
		emit_header();
		emit_body(64);
		for (int i = 0; i < 3; i++) send_file(cuts[i]);
		// huge size word: file ends long before the data does
		build_header(1'b1, 1'b1, 2, 32'd512, 32'd256, 0);
		mip_len[0] = 32'hFFFF_FFF0;
		mip_len[1] = 32'd1;
		emit_header();
		emit_body(12);
		send_file(-1);
	endtask

	// sink holds off while results pile up, so the input must stall;
	// then the source waits for every result before going on
	task automatic test_back_pressure();
		build_header(1'b0, 1'b0, 8, 32'd256, 32'd256, 0);
		for (int i = 0; i < 16; i++) mip_len[i] = 32'd0;
		emit_header();
		emit_body(64);
		hold_req = 300;
		tx_idle_en = 1'b0;
		send_file(-1);
		settle();
		tx_idle_en = 1'b1;
	endtask

	function automatic logic [31:0] pick_dim();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 3);
			2: return 32'd1 << $urandom_range(0, 31);
			default: return $urandom_range(4, 4096);
		endcase
	endfunction

	// mostly well-formed files with random content, then cuts, header
	// damage, oversized levels and plain noise
	task automatic test_random();
		int b0, mode, nm, cut, sel, kv;
		logic [31:0] v;
		b0 = bytes_sent;
		while ((bytes_sent - b0) < RANDOM_BYTES) begin
			tx_idle_en = ($urandom_range(0, 4) != 0);
			rx_idle_en = ($urandom_range(0, 4) != 0);
			mode = $urandom_range(0, 99);
			nm = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16) : $urandom_range(0, 4);
			kv = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			build_header(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), nm,
				pick_dim(), pick_dim(), kv);
			for (int i = 0; i < 16; i++)
				mip_len[i] = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			cut = -1;
			if (mode < 60) begin
				emit_header();
				emit_body(64);
				if ($urandom_range(0, 2) == 0) add_junk($urandom_range(1, 3));
			end else if (mode < 75) begin
				emit_header();
				emit_body(64);
				cut = $urandom_range(0, file_q.size() - 1);
			end else if (mode < 87) begin
				v = $urandom;
				sel = $urandom_range(0, 9);
				case (sel)
					0: hdr_val[4] = v;
					1: hdr_val[5] = v;
					2: hdr_val[6] = v;
					3: hdr_val[7] = v;
					4: hdr_val[11] = v;
					5: hdr_val[12] = v;
					6: hdr_val[13] = v;
					7: hdr_val[14] = v[0] ? v
						: $urandom_range(ktx1_pkg::MIP_LIMIT_DEF + 1, 40);
					default: ;
				endcase
				emit_header();
				if (sel == 8) file_q[$urandom_range(0, 11)] ^= 8'($urandom_range(1, 255));
				if (sel == 9) file_q[$urandom_range(12, 15)] = 8'($urandom);
				emit_body(64);
			end else if (mode < 93) begin
				mip_len[0] = $urandom;
				if (nm == 0) hdr_val[14] = 32'd1;
				emit_header();
				emit_body(24);
			end else begin
				file_q.delete();
				add_junk($urandom_range(1, 90));
			end
			send_file(cut);
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	initial begin
		prs_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_files();
		settle();
		test_header_checks();
		settle();
		test_byte_orders();
		test_zero_mips();
		settle();
		test_empty_mips();
		settle();
		test_unaligned_kv();
		settle();
		test_mip_limit();
		settle();
		test_truncation();
		settle();
		test_back_pressure();
		settle();
		test_random();
		settle();
		if (parse_results.size() != 0) begin
			errors++;
			$display("%0t ns: results left over, expected %0d more, got 0", $time,
				parse_results.size());
		end
		$display("Sent %0d files in %0d bytes (short, damaged, truncated, both byte orders)",
			files_sent, bytes_sent);
		$display("Checked %0d results with random stalls on both sides", results_seen);
		if (errors == 0) begin
			$display("PASS ktx1_texture_header_parser");
		end else begin
			$display("FAIL ktx1_texture_header_parser");
		end
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("FAIL ktx1_texture_header_parser");
		$finish;
	end

endmodule
